// ----- rtl/insertion_ordered_int_set_defines.svh -----
// Assertion macros used by the insertion-ordered set RTL.
`ifndef INSERTION_ORDERED_INT_SET_DEFINES_SVH
`define INSERTION_ORDERED_INT_SET_DEFINES_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define IOSET_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);
// Property whose consequent must hold in the cycle after the antecedent.
`define IOSET_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define IOSET_ASSERT(lbl, prop, msg)
`define IOSET_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ----- rtl/ioset_pkg.sv -----
// Package for the insertion-ordered set: request codes, item types and defaults.
package ioset_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int VALUE_W      = 32;
    localparam int COUNT_OUT_W  = 6;

    localparam logic [1:0] KIND_TEST   = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    typedef struct packed {
        logic [1:0]                kind;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic                   outcome;
        logic                   overflow;
        logic [COUNT_OUT_W-1:0] member_count;
        logic                   empty_flag;
    } t_out_item;

endpackage

// ----- rtl/ioset_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module ioset_ram
    import ioset_pkg::*;
#(
    parameter int WIDTH = VALUE_W,
    parameter int DEPTH = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/insertion_ordered_int_set.sv -----
// Insertion-ordered set of distinct 32-bit integers, held packed in one RAM.
//
// A request walks the stored members one RAM read a cycle, in order of first
// membership. A removal writes each later member one place down as the walk
// passes it, and an add appends at the end once the walk has found no match.
// A request thus walks all count members (count being the number of members
// when it is accepted, at most CAPACITY), paced by the single read port of
// the entry RAM; a clear or a request on an empty set skips the walk. The
// result item sits in an output register, so the next request is taken
// while an earlier result waits; its own result waits in turn until the
// output register is free. No new request is taken during a walk.
`include "insertion_ordered_int_set_defines.svh"

module insertion_ordered_int_set
    import ioset_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    logic [1:0]         r_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_rd_idx;
    logic [CW-1:0]      r_chk_idx;
    logic               r_found;
    logic [1:0]         r_kind;
    logic [VALUE_W-1:0] r_value;
    logic               r_out_valid;
    t_out_item          r_out_item;

    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               mem_re;
    logic [IW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;

    logic               hit;
    logic               last;
    logic               out_go;
    logic               dec_outcome;
    logic               dec_overflow;
    logic [CW-1:0]      dec_count;

    ioset_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(CAPACITY)
    ) u_entries (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign hit    = (mem_rdata == r_value);
    assign last   = (r_chk_idx == r_count - CW'(1));
    assign out_go = (r_state == ST_DECIDE) && (!r_out_valid || i_out_ready);

    always_comb begin
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = r_value;
        mem_re       = 1'b0;
        mem_raddr    = '0;
        dec_outcome  = 1'b0;
        dec_overflow = 1'b0;
        dec_count    = r_count;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_in_item.kind != KIND_CLEAR && r_count != '0) begin
                    mem_re = 1'b1;
                end
            end
            ST_SCAN: begin
                mem_re    = (r_rd_idx < r_count);
                mem_raddr = r_rd_idx[IW-1:0];
                // Once the match is behind us, every member read moves down one place.
                if (r_kind == KIND_REMOVE && r_found) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_chk_idx[IW-1:0] - IW'(1);
                    mem_wdata = mem_rdata;
                end
            end
            ST_DECIDE: begin
                case (r_kind)
                    KIND_TEST: begin
                        dec_outcome = r_found;
                    end
                    KIND_ADD: begin
                        if (!r_found && r_count < CW'(CAPACITY)) begin
                            mem_we      = out_go;
                            mem_waddr   = r_count[IW-1:0];
                            dec_count   = r_count + CW'(1);
                            dec_outcome = 1'b1;
                        end else if (!r_found) begin
                            dec_overflow = 1'b1;
                        end
                    end
                    KIND_REMOVE: begin
                        if (r_found) begin
                            dec_count   = r_count - CW'(1);
                            dec_outcome = 1'b1;
                        end
                    end
                    default: begin
                        dec_count   = '0;
                        dec_outcome = 1'b1;
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_chk_idx   <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_found   <= 1'b0;
                        r_rd_idx  <= CW'(1);
                        r_chk_idx <= '0;
                        if (i_in_item.kind == KIND_CLEAR || r_count == '0) begin
                            r_state <= ST_DECIDE;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (mem_re) begin
                        r_rd_idx <= r_rd_idx + CW'(1);
                    end
                    r_found <= r_found | hit;
                    if (last) begin
                        r_state <= ST_DECIDE;
                    end else begin
                        r_chk_idx <= r_chk_idx + CW'(1);
                    end
                end
                ST_DECIDE: begin
                    if (out_go) begin
                        r_count <= dec_count;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_kind  <= i_in_item.kind;
            r_value <= i_in_item.value;
        end
        if (out_go) begin
            r_out_item.outcome      <= dec_outcome;
            r_out_item.overflow     <= dec_overflow;
            r_out_item.member_count <= COUNT_OUT_W'(dec_count);
            r_out_item.empty_flag   <= (dec_count == '0);
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `IOSET_ASSERT(a_count_bound, r_count <= CW'(CAPACITY), "member count exceeds capacity")
    `IOSET_ASSERT(a_scan_in_range,
        (r_state != ST_SCAN) || (r_chk_idx < r_count),
        "scan index beyond members")
    `IOSET_ASSERT(a_shift_only_remove,
        !(r_state == ST_SCAN && mem_we) || (r_kind == KIND_REMOVE && r_found),
        "entry written during scan outside a removal")
    `IOSET_ASSERT_NEXT(a_count_steady, !out_go, $stable(r_count),
        "member count changed outside a decision")
    `IOSET_ASSERT_NEXT(a_add_appends,
        out_go && r_kind == KIND_ADD && !r_found && r_count < CW'(CAPACITY),
        r_count == $past(r_count) + CW'(1),
        "add of an absent value did not grow the set")

endmodule
